// ===== hw/rtl/hmf_pkg.sv =====
`default_nettype none

package hmf_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int LEN_BITS_DEF   = 32;
  localparam int CMP_BITS       = 32;

  localparam int QUEUE_DEPTH    = 4;

  localparam int APB_ADDR_BITS  = 3;
  localparam logic REG_MAX_MESSAGE_BYTES = 1'b0;
  localparam logic [23:0] MAX_BYTES_RESET = 24'd65536;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_CLOSE = 1'b1;

  localparam logic [3:0] NAME_LEN = 4'd14;

  localparam logic [7:0] CHAR_NL    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_VT    = 8'h0b;
  localparam logic [7:0] CHAR_FF    = 8'h0c;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  typedef enum logic [2:0] {
    PH_NAME,
    PH_COLON,
    PH_SPACE,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  // A classified item as it waits between the front and the back.
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [7:0] lower;
    logic       is_nl;
    logic       is_cr;
    logic       is_colon;
    logic       is_space;
    logic       is_digit;
    logic       is_plus;
    logic       is_minus;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic        full;
  } queue_status_t;

  typedef struct packed {
    logic        overflow;
    logic        length_invalid;
    logic [23:0] message_length;
    logic [31:0] content_length;
    logic [23:0] header_length;
    logic        message_end;
    logic        header_end;
    logic        in_header;
    logic [7:0]  out_byte;
  } result_t;

  function automatic logic [7:0] name_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h63; // c
      4'd1:    c = 8'h6f; // o
      4'd2:    c = 8'h6e; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6e; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2d; // -
      4'd8:    c = 8'h6c; // l
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6e; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hmf_front.sv =====
`default_nettype none

module hmf_front
  import hmf_pkg::*;
(
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,  // data_byte
  input  wire logic          s_tuser,  // kind
  input  wire queue_status_t q_status,
  output logic               push,
  output item_t              push_item
);

  logic [7:0] b;

  assign b        = s_tdata;
  assign s_tready = !q_status.full;
  assign push     = s_tvalid && !q_status.full;

  always_comb begin
    push_item.kind     = s_tuser;
    push_item.data     = b;
    push_item.lower    = (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ? b + CASE_OFFSET : b;
    push_item.is_nl    = (b == CHAR_NL);
    push_item.is_cr    = (b == CHAR_CR);
    push_item.is_colon = (b == CHAR_COLON);
    push_item.is_space = (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_NL) ||
                         (b == CHAR_VT) || (b == CHAR_FF) || (b == CHAR_CR);
    push_item.is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    push_item.is_plus  = (b == CHAR_PLUS);
    push_item.is_minus = (b == CHAR_MINUS);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hmf_queue.sv =====
`default_nettype none

module hmf_queue
  import hmf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      head,
  output queue_status_t status
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(QUEUE_DEPTH);

  item_t               entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign head         = entries[rd_ptr];
  assign status.valid = (count != '0);
  assign status.full  = (count == FULL_CNT);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("queue count beyond its depth");
  assert property (@(posedge clk) disable iff (rst)
                   (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");
  assert property (@(posedge clk) disable iff (rst)
                   (pop && !push) |=> count == $past(count) - 1'b1)
    else $error("queue count missed a pop");

endmodule

`default_nettype wire

// ===== hw/rtl/hmf_back.sv =====
`default_nettype none

module hmf_back
  import hmf_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int LEN_BITS   = LEN_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [23:0]   max_message_bytes,
  input  wire queue_status_t q_status,
  input  wire item_t         head,
  output logic               pop,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output result_t            result
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [LEN_BITS-1:0]   LEN_MAX   = {LEN_BITS{1'b1}};

  logic                  prev_newline, prev_newline_next;
  logic                  header_found, header_found_next;
  logic                  at_line_start, at_line_start_next;
  logic [3:0]            match_pos, match_pos_next;
  phase_t                length_phase, length_phase_next;
  logic [LEN_BITS-1:0]   length_value, length_value_next;
  logic                  length_negative, length_negative_next;
  logic [COUNT_BITS-1:0] header_count, header_count_next;
  logic [COUNT_BITS-1:0] byte_count, byte_count_next;

  logic [COUNT_BITS-1:0] count_inc;
  logic [COUNT_BITS-1:0] body_count;
  logic [LEN_BITS+3:0]   digit_sum;
  logic [LEN_BITS-1:0]   digit_value;
  logic                  header_done;
  logic                  complete;
  logic                  clear;
  result_t               res;

  assign pop       = q_status.valid && (!m_tvalid || m_tready);
  assign count_inc = (byte_count != COUNT_MAX) ? byte_count + 1'b1 : byte_count;
  assign body_count = count_inc - header_count;

  // Times ten as two shifts and an add, saturated to the length width.
  assign digit_sum = {length_value, 3'b000} + {2'b00, length_value, 1'b0} +
                     (LEN_BITS+4)'(head.data[3:0]);
  assign digit_value = (digit_sum > (LEN_BITS+4)'(LEN_MAX)) ? LEN_MAX
                                                            : LEN_BITS'(digit_sum);

  always_comb begin
    prev_newline_next    = prev_newline;
    header_found_next    = header_found;
    at_line_start_next   = at_line_start;
    match_pos_next       = match_pos;
    length_phase_next    = length_phase;
    length_value_next    = length_value;
    length_negative_next = length_negative;
    header_count_next    = header_count;
    byte_count_next      = byte_count;
    header_done          = 1'b0;
    complete             = 1'b0;
    clear                = 1'b0;
    res                  = '0;

    if (pop) begin
      if (head.kind == KIND_CLOSE) begin
        clear = 1'b1;
      end else begin
        res.out_byte    = head.data;
        byte_count_next = count_inc;
        if (!header_found) begin
          res.in_header = 1'b1;
          unique case (length_phase)
            PH_NAME: begin
              if (at_line_start) begin
                if (match_pos < NAME_LEN && head.lower == name_char(match_pos)) begin
                  match_pos_next = match_pos + 1'b1;
                  if (match_pos == NAME_LEN - 1'b1) begin
                    length_phase_next = PH_COLON;
                  end
                end else begin
                  at_line_start_next = 1'b0;
                end
              end
              if (head.is_nl) begin
                at_line_start_next = 1'b1;
                match_pos_next     = '0;
              end
            end
            PH_COLON: begin
              if (head.is_colon) begin
                length_phase_next = PH_SPACE;
              end
            end
            PH_SPACE: begin
              priority if (head.is_space) begin
                length_phase_next = PH_SPACE;
              end else if (head.is_plus || head.is_minus) begin
                length_negative_next = head.is_minus;
                length_phase_next    = PH_DIGITS;
              end else if (head.is_digit) begin
                length_value_next = digit_value;
                length_phase_next = PH_DIGITS;
              end else begin
                length_phase_next = PH_DONE;
              end
            end
            PH_DIGITS: begin
              if (head.is_digit) begin
                length_value_next = digit_value;
              end else begin
                length_phase_next = PH_DONE;
              end
            end
            PH_DONE: begin
              length_phase_next = PH_DONE;
            end
            default: begin
              length_phase_next = length_phase;
            end
          endcase

          header_done = head.is_nl && prev_newline;
          if (head.is_nl) begin
            prev_newline_next = 1'b1;
          end else if (!head.is_cr) begin
            prev_newline_next = 1'b0;
          end

          if (header_done) begin
            res.header_end    = 1'b1;
            header_found_next = 1'b1;
            header_count_next = count_inc;
            if (length_negative_next) begin
              length_value_next = '0;
            end
            complete = (length_value_next == '0);
          end
        end else begin
          complete = CMP_BITS'(body_count) >= CMP_BITS'(length_value);
        end

        if (complete) begin
          res.message_end    = 1'b1;
          res.header_length  = 24'(header_count_next);
          res.content_length = 32'(length_value_next);
          res.message_length = 24'(count_inc);
          res.length_invalid = length_negative_next;
          clear              = 1'b1;
        end else if (CMP_BITS'(count_inc) >= CMP_BITS'(max_message_bytes) ||
                     count_inc == COUNT_MAX) begin
          res.overflow = 1'b1;
          clear        = 1'b1;
        end
      end
    end

    if (clear) begin
      prev_newline_next    = 1'b0;
      header_found_next    = 1'b0;
      at_line_start_next   = 1'b1;
      match_pos_next       = '0;
      length_phase_next    = PH_NAME;
      length_value_next    = '0;
      length_negative_next = 1'b0;
      header_count_next    = '0;
      byte_count_next      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_newline    <= 1'b0;
      header_found    <= 1'b0;
      at_line_start   <= 1'b1;
      match_pos       <= '0;
      length_phase    <= PH_NAME;
      length_value    <= '0;
      length_negative <= 1'b0;
      header_count    <= '0;
      byte_count      <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      prev_newline    <= prev_newline_next;
      header_found    <= header_found_next;
      at_line_start   <= at_line_start_next;
      match_pos       <= match_pos_next;
      length_phase    <= length_phase_next;
      length_value    <= length_value_next;
      length_negative <= length_negative_next;
      header_count    <= header_count_next;
      byte_count      <= byte_count_next;
      if (pop) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= res;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
                   m_tvalid |-> !(result.message_end && result.overflow))
    else $error("message end and overflow on the same item");
  assert property (@(posedge clk) disable iff (rst)
                   (m_tvalid && result.header_end) |-> result.in_header)
    else $error("header end outside the header");
  assert property (@(posedge clk) disable iff (rst)
                   header_found |-> (!length_negative && length_value != '0))
    else $error("body phase entered without a positive length");
  assert property (@(posedge clk) disable iff (rst)
                   (m_tvalid && !m_tready) |=> m_tvalid && $stable(result))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== hw/rtl/http_message_framer.sv =====
// HTTP message framer: splits a received TCP byte stream into messages.
// The input stream carries one item per received byte (s_tuser = 0) or a
// close/receive-error marker (s_tuser = 1). Every input item produces
// exactly one output item: the byte itself with in_header and header_end
// flags, and on the byte that completes a message m_tlast high together
// with the header, content and message lengths. overflow marks a byte at
// which the size limit was reached and the partial message was dropped.
// The APB port holds max_message_bytes at address 0 (reset value 65536).
// An accepted item is first written into the four-entry queue by the
// accepting edge; when it reaches the head of the queue and is popped, the
// popping edge carries it through the parser into the output register.
// Sustained throughput is one item per cycle while the receiver does not
// stall, set by the parser update in the back end. When the receiver
// stalls, the output item is held, the queue absorbs up to four more
// items and then s_tready falls. Synchronous reset empties the queue and
// the output register, clears the parser and reloads max_message_bytes.
`default_nettype none

module http_message_framer
  import hmf_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int LEN_BITS   = LEN_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [7:0]               s_tdata,  // data_byte
  input  wire logic                     s_tuser,  // kind
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // out_byte [7:0], header_length [31:8], content_length [63:32],
  // message_length [87:64]
  output logic [87:0]                   m_tdata,
  // in_header [0], header_end [1], length_invalid [2], overflow [3]
  output logic [3:0]                    m_tuser,
  output logic                          m_tlast,  // message_end
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]              pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [23:0]   max_message_bytes;
  logic          push;
  item_t         push_item;
  logic          pop;
  item_t         head;
  queue_status_t q_status;
  result_t       result;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_MESSAGE_BYTES) ? {8'h00, max_message_bytes} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_bytes <= MAX_BYTES_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_MAX_MESSAGE_BYTES) begin
      max_message_bytes <= pwdata[23:0];
    end
  end

  hmf_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  hmf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  hmf_back #(
    .COUNT_BITS (COUNT_BITS),
    .LEN_BITS   (LEN_BITS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .max_message_bytes (max_message_bytes),
    .q_status          (q_status),
    .head              (head),
    .pop               (pop),
    .m_tvalid          (m_tvalid),
    .m_tready          (m_tready),
    .result            (result)
  );

  assign m_tdata = {result.message_length, result.content_length,
                    result.header_length, result.out_byte};
  assign m_tuser = {result.overflow, result.length_invalid,
                    result.header_end, result.in_header};
  assign m_tlast = result.message_end;

endmodule

`default_nettype wire
